### rtl/mcpwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared constants for the multi-channel PWM generator: parameter defaults,
// request kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    // parameter defaults
    localparam int DEF_NUM_PINS         = 28;
    localparam int DEF_TICKS_PER_SECOND = 1000000;

    // full-scale duty
    localparam logic [7:0] DUTY_FULL = 8'd255;

    // configuration reset values
    localparam logic [15:0] MIN_FREQ_RESET = 16'd1;
    localparam logic [15:0] MAX_FREQ_RESET = 16'd10000;

    // request kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_SET_DUTY = 3'd2;
    localparam logic [2:0] KIND_STOP     = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NOT_ACTIVE  = 2'd1;
    localparam logic [1:0] STATUS_INVALID_PIN = 2'd2;

    // configuration register indexes
    localparam logic CFG_MIN_FREQ = 1'b0;
    localparam logic CFG_MAX_FREQ = 1'b1;

endpackage
`default_nettype wire

### rtl/mcpwm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpwm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcpwm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/mcpwm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcpwm_div
// Iterative restoring divider, one quotient bit per cycle; done pulses for
// one cycle once the quotient is final.
// ----------------------------------------------------------------------------
module mcpwm_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   rem_next;

    // one shift-subtract step
    always_comb
    begin
        shifted  = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= numer;
            den_reg  <= denom;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

### rtl/multi_channel_pwm_generator_unit.sv
// Requests: a tick sweeps the state RAM, one channel per cycle; others read
// their channel word, then a new start runs the bit-serial period divide and
// three high-time steps, start or set duty on a running channel just the steps,
// stop and query finish. Invalid pin or unknown kind answer from idle.
// One request at a time: busy drops in the strobe cycle. Results cannot be
// stalled. Reset stops all channels; the RAM needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator_unit
// PWM bank with one channel per pin. Channel state lives in one RAM and is
// read, updated and written back by a request sequencer.
// ----------------------------------------------------------------------------
module multi_channel_pwm_generator_unit #(
    parameter int NUM_PINS         = mcpwm_pkg::DEF_NUM_PINS,
    parameter int TICKS_PER_SECOND = mcpwm_pkg::DEF_TICKS_PER_SECOND
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          kind,
    input  wire logic [4:0]          pin,
    input  wire logic [15:0]         duty,
    input  wire logic [15:0]         frequency,
    output logic                     done,
    output logic      [1:0]          status,
    output logic                     was_active,
    output logic      [7:0]          duty_out,
    output logic      [15:0]         frequency_out,
    output logic      [4:0]          active_count,
    output logic      [NUM_PINS-1:0] pin_levels,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);

    import mcpwm_pkg::*;

    localparam int PERIOD_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int PROD_W   = PERIOD_W + 8;
    localparam int EST_W    = PERIOD_W + 32;
    localparam int ADDR_W   = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int CNT_W    = $clog2(NUM_PINS + 1);

    // (2^32-1)/255, reciprocal of full-scale duty in 32 fraction bits
    localparam logic [31:0] RECIP_FULL = 32'h0101_0101;

    typedef struct packed {
        logic [7:0]          duty;
        logic [15:0]         freq;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] next_high;
        logic [PERIOD_W-1:0] high;
        logic [PERIOD_W-1:0] phase;
    } word_t;

    localparam int WORD_W = $bits(word_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_DIVP,
        S_MUL,
        S_EST,
        S_HIGH,
        S_TICK
    } state_t;

    state_t              state_reg;
    logic [NUM_PINS-1:0] on_reg;
    logic [NUM_PINS-1:0] level_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [15:0]         min_reg;
    logic [15:0]         max_reg;
    logic                done_reg;

    logic [2:0]          kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [7:0]          duty_reg;
    logic [15:0]         freq_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PERIOD_W-1:0] est_reg;
    logic                new_reg;
    word_t               word_reg;
    logic [1:0]          status_reg;
    logic                was_reg;
    logic [7:0]          duty_out_reg;
    logic [15:0]         freq_out_reg;

    // request decode
    logic [ADDR_W+4:0]   pin_wide;
    logic [ADDR_W-1:0]   pin_addr;
    logic                pin_ok;
    logic [7:0]          duty_clamped;
    logic [15:0]         freq_clamped;

    always_comb
    begin
        pin_wide     = {{ADDR_W{1'b0}}, pin};
        pin_addr     = pin_wide[ADDR_W-1:0];
        pin_ok       = (32'(pin) < NUM_PINS);
        duty_clamped = (duty > 16'(DUTY_FULL)) ? DUTY_FULL : duty[7:0];
        freq_clamped = frequency;
        if (freq_clamped < min_reg)
        begin
            freq_clamped = min_reg;
        end
        if (freq_clamped > max_reg)
        begin
            freq_clamped = max_reg;
        end
        if (freq_clamped == 16'd0)
        begin
            freq_clamped = 16'd1;
        end
    end

    // memory and divider
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    word_t               ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    word_t               ram_rdata;
    logic                div_start;
    logic [PERIOD_W-1:0] div_numer;
    logic [15:0]         div_denom;
    logic                div_done;
    logic [PERIOD_W-1:0] div_quot;

    mcpwm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_PINS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    mcpwm_div #(
        .NUM_W(PERIOD_W),
        .DEN_W(16)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .numer(div_numer),
        .denom(div_denom),
        .done (div_done),
        .quot (div_quot)
    );

    // tick sweep: read channel cnt, update channel cnt-1
    logic [CNT_W-1:0]    cnt_prev;
    logic [ADDR_W-1:0]   stage_addr;
    logic                stage_on;
    logic [PERIOD_W-1:0] tk_high;
    logic [PERIOD_W:0]   tk_inc;
    logic                tk_level;
    word_t               tk_word;
    logic                cmd_was;
    logic [PERIOD_W-1:0] q_period;

    always_comb
    begin
        cnt_prev   = cnt_reg - 1'b1;
        stage_addr = cnt_prev[ADDR_W-1:0];
        stage_on   = (state_reg == S_TICK) && (cnt_reg != '0) && on_reg[stage_addr];
        tk_high    = (ram_rdata.phase == '0) ? ram_rdata.next_high : ram_rdata.high;
        tk_level   = (ram_rdata.phase < tk_high);
        tk_inc     = {1'b0, ram_rdata.phase} + 1'b1;
        tk_word    = ram_rdata;
        tk_word.high  = tk_high;
        tk_word.phase = (tk_inc >= {1'b0, ram_rdata.period}) ? '0 : tk_inc[PERIOD_W-1:0];
        cmd_was    = on_reg[addr_reg];
        q_period   = (div_quot == '0) ? PERIOD_W'(1) : div_quot;
    end

    // high time from the product: reciprocal estimate, then one correction step
    logic [EST_W-1:0]    est_full;
    logic [PERIOD_W-1:0] est_q;
    logic [PROD_W-1:0]   rem_est;
    logic [PERIOD_W-1:0] high_val;

    always_comb
    begin
        est_full = EST_W'(prod_reg) * EST_W'(RECIP_FULL);
        est_q    = est_full[EST_W-1:32];
        rem_est  = prod_reg - {est_reg, 8'b0} + PROD_W'(est_reg);
        high_val = est_reg + PERIOD_W'(rem_est >= PROD_W'(DUTY_FULL));
    end

    // memory port and divider operand selection
    always_comb
    begin
        if (state_reg == S_TICK)
        begin
            ram_raddr = (cnt_reg < CNT_W'(NUM_PINS)) ? cnt_reg[ADDR_W-1:0] : '0;
        end
        else
        begin
            ram_raddr = pin_addr;
        end

        div_start = (state_reg == S_CMD) && (kind_reg == KIND_START) && !cmd_was;
        div_numer = PERIOD_W'(TICKS_PER_SECOND);
        div_denom = freq_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = tk_word;
        if (stage_on)
        begin
            ram_we    = 1'b1;
            ram_waddr = stage_addr;
        end
        else if (state_reg == S_HIGH)
        begin
            ram_we    = 1'b1;
            ram_wdata = word_reg;
            ram_wdata.duty      = duty_reg;
            ram_wdata.next_high = high_val;
            if (new_reg)
            begin
                ram_wdata.freq   = freq_reg;
                ram_wdata.period = period_reg;
                ram_wdata.high   = '0;
                ram_wdata.phase  = '0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_FREQ_RESET;
            max_reg <= MAX_FREQ_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MIN_FREQ)
            begin
                min_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_FREQ)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // request sequencer: state, channel flags and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            on_reg    <= '0;
            level_reg <= '0;
            count_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg     <= kind;
                        addr_reg     <= pin_addr;
                        duty_reg     <= duty_clamped;
                        freq_reg     <= freq_clamped;
                        status_reg   <= STATUS_OK;
                        was_reg      <= 1'b0;
                        duty_out_reg <= '0;
                        freq_out_reg <= '0;
                        if (kind == KIND_TICK)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_TICK;
                        end
                        else if (kind > KIND_QUERY)
                        begin
                            done_reg <= 1'b1;
                        end
                        else if (!pin_ok)
                        begin
                            status_reg <= STATUS_INVALID_PIN;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_CMD;
                        end
                    end
                end

                S_CMD:
                begin
                    word_reg   <= ram_rdata;
                    period_reg <= ram_rdata.period;
                    new_reg    <= !cmd_was;
                    was_reg    <= cmd_was;
                    state_reg  <= S_IDLE;
                    case (kind_reg)
                        KIND_START:
                        begin
                            state_reg <= cmd_was ? S_MUL : S_DIVP;
                        end
                        KIND_SET_DUTY:
                        begin
                            if (cmd_was)
                            begin
                                state_reg <= S_MUL;
                            end
                            else
                            begin
                                status_reg <= STATUS_NOT_ACTIVE;
                                done_reg   <= 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            if (cmd_was)
                            begin
                                on_reg[addr_reg]    <= 1'b0;
                                level_reg[addr_reg] <= 1'b0;
                                count_reg           <= count_reg - 1'b1;
                            end
                            else
                            begin
                                status_reg <= STATUS_NOT_ACTIVE;
                            end
                            done_reg <= 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            if (cmd_was)
                            begin
                                duty_out_reg <= ram_rdata.duty;
                                freq_out_reg <= ram_rdata.freq;
                            end
                            else
                            begin
                                status_reg <= STATUS_NOT_ACTIVE;
                            end
                            done_reg <= 1'b1;
                        end
                        default:
                        begin
                            done_reg <= 1'b1;
                        end
                    endcase
                end

                // period of a new channel
                S_DIVP:
                begin
                    if (div_done)
                    begin
                        period_reg <= q_period;
                        state_reg  <= S_MUL;
                    end
                end

                // product of period and duty
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(period_reg) * PROD_W'(duty_reg);
                    state_reg <= S_EST;
                end

                // reciprocal estimate of the product over full-scale duty
                S_EST:
                begin
                    est_reg   <= est_q;
                    state_reg <= S_HIGH;
                end

                // corrected high time goes to the RAM, request finishes
                S_HIGH:
                begin
                    if (new_reg)
                    begin
                        on_reg[addr_reg]    <= 1'b1;
                        level_reg[addr_reg] <= 1'b0;
                        count_reg           <= count_reg + 1'b1;
                        freq_out_reg        <= freq_reg;
                    end
                    else
                    begin
                        freq_out_reg <= word_reg.freq;
                    end
                    duty_out_reg <= duty_reg;
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end

                S_TICK:
                begin
                    if (stage_on)
                    begin
                        level_reg[stage_addr] <= tk_level;
                    end
                    if (cnt_reg == CNT_W'(NUM_PINS))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    logic [CNT_W+4:0] count_wide;

    assign count_wide    = {5'b0, count_reg};
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign was_active    = was_reg;
    assign duty_out      = duty_out_reg;
    assign frequency_out = freq_out_reg;
    assign active_count  = count_wide[4:0];
    assign pin_levels    = level_reg;

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM generator bank. A clocked driver feeds
// requests and register writes from a queue, a built-in channel model
// predicts every response at acceptance, and a clocked monitor compares
// each response strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import mcpwm_pkg::*;

    localparam int NUM_PINS = DEF_NUM_PINS;
    localparam int TPS      = DEF_TICKS_PER_SECOND;

    // kinds that the bank ignores and answers like a tick
    localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

    // pin numbers at the edges of the address space
    localparam logic [4:0] PIN_LAST    = 5'd27;
    localparam logic [4:0] PIN_BAD_LO  = 5'd28;
    localparam logic [4:0] PIN_BAD_HI  = 5'd31;

    typedef enum logic [1:0] {ENT_REQ, ENT_CFG, ENT_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t ent;
        logic [2:0]  kind;
        logic [4:0]  pin;
        logic [15:0] duty;
        logic [15:0] freq;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        int          gap;
        bit          gap_from_idle;
    } pwm_cmd_t;

    typedef struct {
        logic [1:0]          status;
        logic                was_active;
        logic [7:0]          duty_out;
        logic [15:0]         freq_out;
        logic [4:0]          active_count;
        logic [NUM_PINS-1:0] levels;
    } pwm_rsp_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // dut ports
    logic                start     = 1'b0;
    logic [2:0]          kind      = KIND_TICK;
    logic [4:0]          pin       = '0;
    logic [15:0]         duty      = '0;
    logic [15:0]         frequency = '0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_MIN_FREQ;
    logic [15:0]         cfg_data  = '0;
    logic                busy;
    logic                done;
    logic [1:0]          status;
    logic                was_active;
    logic [7:0]          duty_out;
    logic [15:0]         frequency_out;
    logic [4:0]          active_count;
    logic [NUM_PINS-1:0] pin_levels;

    multi_channel_pwm_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pin           (pin),
        .duty          (duty),
        .frequency     (frequency),
        .done          (done),
        .status        (status),
        .was_active    (was_active),
        .duty_out      (duty_out),
        .frequency_out (frequency_out),
        .active_count  (active_count),
        .pin_levels    (pin_levels),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // bench bookkeeping
    pwm_cmd_t cmd_queue[$];
    pwm_rsp_t pending_results[$];
    int       issued_count = 0;
    int       results_seen = 0;
    int       mismatches   = 0;
    bit       idle_on      = 1'b1;

    // channel model state
    bit [15:0]       min_freq = MIN_FREQ_RESET;
    bit [15:0]       max_freq = MAX_FREQ_RESET;
    bit              ch_on     [NUM_PINS];
    bit [7:0]        ch_duty   [NUM_PINS];
    bit [15:0]       ch_freq   [NUM_PINS];
    int unsigned     ch_phase  [NUM_PINS];
    int unsigned     ch_period [NUM_PINS];
    int unsigned     ch_high   [NUM_PINS];
    bit [NUM_PINS-1:0] level_bits = '0;
    int unsigned     n_running  = 0;

    function automatic bit [7:0] limit_duty(logic [15:0] d);
        return (d > DUTY_FULL) ? DUTY_FULL : d[7:0];
    endfunction

    function automatic bit [15:0] limit_freq(logic [15:0] f);
        bit [15:0] r;
        r = f;
        if (r < min_freq) r = min_freq;
        if (r > max_freq) r = max_freq;
        if (r == 0) r = 16'd1;
        return r;
    endfunction

    // one microsecond of time for every running channel
    function automatic void advance_channels();
        int unsigned per;
        for (int p = 0; p < NUM_PINS; p++)
        begin
            if (ch_on[p])
            begin
                if (ch_phase[p] == 0)
                begin
                    per = TPS / ch_freq[p];
                    if (per == 0) per = 1;
                    ch_period[p] = per;
                    ch_high[p]   = int'((longint'(per) * ch_duty[p]) / DUTY_FULL);
                end
                level_bits[p] = (ch_phase[p] < ch_high[p]);
                ch_phase[p]++;
                if (ch_phase[p] >= ch_period[p]) ch_phase[p] = 0;
            end
        end
    endfunction

    // apply one request to the channel model and return its response
    function automatic pwm_rsp_t pwm_bank_step(pwm_cmd_t c);
        pwm_rsp_t r;
        bit       was;
        r.status     = STATUS_OK;
        r.was_active = 1'b0;
        r.duty_out   = '0;
        r.freq_out   = '0;
        was          = 1'b0;
        if (c.kind == KIND_TICK)
        begin
            advance_channels();
        end
        else if (c.kind <= KIND_QUERY)
        begin
            if (c.pin >= NUM_PINS)
            begin
                r.status = STATUS_INVALID_PIN;
            end
            else
            begin
                was = ch_on[c.pin];
                if (c.kind == KIND_START)
                begin
                    ch_duty[c.pin] = limit_duty(c.duty);
                    if (!was)
                    begin
                        ch_freq[c.pin]   = limit_freq(c.freq);
                        ch_phase[c.pin]  = 0;
                        ch_period[c.pin] = 0;
                        ch_high[c.pin]   = 0;
                        level_bits[c.pin] = 1'b0;
                        ch_on[c.pin]     = 1'b1;
                        n_running++;
                    end
                end
                else if (!was)
                begin
                    r.status = STATUS_NOT_ACTIVE;
                end
                else if (c.kind == KIND_SET_DUTY)
                begin
                    ch_duty[c.pin] = limit_duty(c.duty);
                end
                else if (c.kind == KIND_STOP)
                begin
                    ch_on[c.pin]      = 1'b0;
                    level_bits[c.pin] = 1'b0;
                    n_running--;
                end
                r.was_active = was;
                if (ch_on[c.pin])
                begin
                    r.duty_out = ch_duty[c.pin];
                    r.freq_out = ch_freq[c.pin];
                end
            end
        end
        r.active_count = n_running[4:0];
        r.levels       = level_bits;
        return r;
    endfunction

    // request driver: one nonblocking update per signal per edge
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        pwm_cmd_t   head;
        pwm_cmd_t   driven;
        int         wait_cnt;
        logic       accepted;
        logic       nxt_start;
        logic [2:0] nxt_kind;
        logic [4:0] nxt_pin;
        logic [15:0] nxt_duty;
        logic [15:0] nxt_freq;
        logic       nxt_we;
        logic       nxt_idx;
        logic [15:0] nxt_data;
        if (!rst_n)
        begin
            start     <= 1'b0;
            kind      <= KIND_TICK;
            pin       <= '0;
            duty      <= '0;
            frequency <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= CFG_MIN_FREQ;
            cfg_data  <= '0;
            wait_cnt  = 0;
        end
        else
        begin
            accepted  = start && !busy;
            nxt_start = start && !accepted;
            nxt_kind  = kind;
            nxt_pin   = pin;
            nxt_duty  = duty;
            nxt_freq  = frequency;
            nxt_we    = 1'b0;
            nxt_idx   = cfg_index;
            nxt_data  = cfg_data;
            if (accepted)
            begin
                pending_results.push_back(pwm_bank_step(driven));
                issued_count++;
            end
            if (!nxt_start && cmd_queue.size() > 0)
            begin
                head = cmd_queue[0];
                if (head.ent == ENT_REQ)
                begin
                    if (wait_cnt < head.gap)
                    begin
                        if (!head.gap_from_idle || !busy) wait_cnt++;
                    end
                    else
                    begin
                        void'(cmd_queue.pop_front());
                        wait_cnt  = 0;
                        driven    = head;
                        nxt_start = 1'b1;
                        nxt_kind  = head.kind;
                        nxt_pin   = head.pin;
                        nxt_duty  = head.duty;
                        nxt_freq  = head.freq;
                    end
                end
                else if (!start && issued_count == results_seen)
                begin
                    // bank is idle: register write or plain drain point
                    void'(cmd_queue.pop_front());
                    if (head.ent == ENT_CFG)
                    begin
                        nxt_we   = 1'b1;
                        nxt_idx  = head.cfg_idx;
                        nxt_data = head.cfg_val;
                        if (head.cfg_idx == CFG_MIN_FREQ) min_freq = head.cfg_val;
                        else max_freq = head.cfg_val;
                    end
                end
            end
            start     <= nxt_start;
            kind      <= nxt_kind;
            pin       <= nxt_pin;
            duty      <= nxt_duty;
            frequency <= nxt_freq;
            cfg_we    <= nxt_we;
            cfg_index <= nxt_idx;
            cfg_data  <= nxt_data;
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
            mismatches++;
        end
    endtask

    // response monitor
    always @(posedge clk)
    begin : rsp_monitor
        pwm_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: response strobe with no request outstanding", $time);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("was_active", 32'(want.was_active), 32'(was_active));
                check_field("duty_out", 32'(want.duty_out), 32'(duty_out));
                check_field("frequency_out", 32'(want.freq_out), 32'(frequency_out));
                check_field("active_count", 32'(want.active_count), 32'(active_count));
                check_field("pin_levels", 32'(want.levels), 32'(pin_levels));
            end
            results_seen <= results_seen + 1;
        end
    end

    // queue helpers
    task automatic push_req(input logic [2:0] k, input logic [4:0] p,
                            input logic [15:0] d, input logic [15:0] f);
        pwm_cmd_t c;
        c.ent           = ENT_REQ;
        c.kind          = k;
        c.pin           = p;
        c.duty          = d;
        c.freq          = f;
        c.cfg_idx       = CFG_MIN_FREQ;
        c.cfg_val       = '0;
        c.gap           = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
        c.gap_from_idle = 1'($urandom_range(0, 1));
        cmd_queue.push_back(c);
    endtask

    task automatic push_ctrl(input entry_kind_t e, input logic idx,
                             input logic [15:0] val);
        pwm_cmd_t c;
        c.ent           = e;
        c.kind          = KIND_TICK;
        c.pin           = '0;
        c.duty          = '0;
        c.freq          = '0;
        c.cfg_idx       = idx;
        c.cfg_val       = val;
        c.gap           = 0;
        c.gap_from_idle = 1'b0;
        cmd_queue.push_back(c);
    endtask

    // mostly valid pins and ticks, with some noise
    task automatic add_random(input int n, input bit allow_idle);
        logic [2:0]  k;
        logic [4:0]  p;
        logic [15:0] d;
        logic [15:0] f;
        int          r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0) idle_on = allow_idle && $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 45)      k = KIND_TICK;
            else if (r < 62) k = KIND_START;
            else if (r < 72) k = KIND_SET_DUTY;
            else if (r < 80) k = KIND_STOP;
            else if (r < 94) k = KIND_QUERY;
            else             k = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            p = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(PIN_BAD_LO, PIN_BAD_HI))
                                             : 5'($urandom_range(0, PIN_LAST));
            case ($urandom_range(0, 3))
                0:       d = 16'd0;
                1:       d = 16'(DUTY_FULL);
                2:       d = 16'($urandom_range(0, 255));
                default: d = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
                0:       f = 16'd0;
                1:       f = 16'hFFFF;
                default: f = 16'($urandom_range(0, 65535));
            endcase
            push_req(k, p, d, f);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        // directed part under the reset register values
        push_req(KIND_QUERY, 5'd0, 16'd0, 16'd0);
        push_req(KIND_SET_DUTY, 5'd0, 16'd10, 16'd0);
        push_req(KIND_STOP, 5'd0, 16'd0, 16'd0);
        push_req(KIND_START, PIN_BAD_HI, 16'hFFFF, 16'hFFFF);
        push_req(KIND_QUERY, PIN_BAD_LO, 16'd0, 16'd0);
        push_req(KIND_UNUSED_LO, 5'd3, 16'd0, 16'd0);
        push_req(KIND_UNUSED_HI, PIN_BAD_HI, 16'hFFFF, 16'hFFFF);
        push_req(KIND_START, 5'd0, 16'd0, 16'd0);
        push_req(KIND_START, PIN_LAST, 16'hFFFF, 16'hFFFF);
        push_req(KIND_START, 5'd1, 16'd128, 16'd9999);
        push_req(KIND_START, 5'd1, 16'd300, 16'd1);
        push_req(KIND_TICK, 5'd0, 16'd0, 16'd0);
        push_req(KIND_TICK, 5'd0, 16'd0, 16'd0);
        push_req(KIND_TICK, PIN_BAD_HI, 16'hFFFF, 16'hFFFF);
        push_req(KIND_SET_DUTY, 5'd1, 16'd0, 16'd0);
        push_req(KIND_TICK, 5'd0, 16'd0, 16'd0);
        push_req(KIND_QUERY, PIN_LAST, 16'd0, 16'd0);
        push_req(KIND_STOP, PIN_LAST, 16'd0, 16'd0);
        push_req(KIND_TICK, 5'd0, 16'd0, 16'd0);
        push_req(KIND_UNUSED_MID, 5'd5, 16'd0, 16'd0);
        push_req(KIND_QUERY, 5'd1, 16'd0, 16'd0);

        // full range
        push_ctrl(ENT_CFG, CFG_MIN_FREQ, 16'd1);
        push_ctrl(ENT_CFG, CFG_MAX_FREQ, 16'hFFFF);
        add_random(120, 1'b1);
        push_ctrl(ENT_DRAIN, CFG_MIN_FREQ, 16'd0);
        add_random(80, 1'b1);

        // short periods only
        push_ctrl(ENT_CFG, CFG_MIN_FREQ, 16'd40000);
        add_random(200, 1'b1);

        // minimum above maximum, maximum wins
        push_ctrl(ENT_CFG, CFG_MIN_FREQ, 16'hFFFF);
        push_ctrl(ENT_CFG, CFG_MAX_FREQ, 16'd1);
        add_random(100, 1'b1);

        // zero limits, clamp result raised to one
        push_ctrl(ENT_CFG, CFG_MIN_FREQ, 16'd0);
        push_ctrl(ENT_CFG, CFG_MAX_FREQ, 16'd0);
        add_random(60, 1'b1);
        push_ctrl(ENT_CFG, CFG_MAX_FREQ, 16'hFFFF);
        add_random(140, 1'b1);

        // mid band, no idling to the end
        push_ctrl(ENT_CFG, CFG_MIN_FREQ, 16'd20000);
        push_ctrl(ENT_CFG, CFG_MAX_FREQ, 16'd40000);
        add_random(200, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || issued_count != results_seen)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d predicted responses never arrived",
                     $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/mcpwm_pkg.sv
rtl/mcpwm_ram.sv
rtl/mcpwm_div.sv
rtl/multi_channel_pwm_generator_unit.sv
tb/tb_top.sv
